[hw/rtl/ght_pkg.sv]
// ----------------------------------------------------------------------------
// ght_pkg
// shared types and codes of the generation handle table
// ----------------------------------------------------------------------------
package ght_pkg;

  typedef enum logic [2:0] {
    OpAlloc    = 3'd0,
    OpAssign   = 3'd1,
    OpFree     = 3'd2,
    OpMark     = 3'd3,
    OpUnmark   = 3'd4,
    OpLookup   = 3'd5,
    OpNextUsed = 3'd6,
    OpBad      = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StInvalid = 3'd1,
    StFull    = 3'd2,
    StNotFree = 3'd3,
    StRange   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SInit,
    SRead,
    SDecide,
    SLinkWr,
    SScanRd,
    SScanChk,
    SDone
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic init_step; // clear one entry
    logic rd_entry;  // read entry at target index
    logic decide;    // evaluate op, write entry state
    logic wr_link;   // patch neighbours
    logic scan_rd;   // read scan entry
    logic scan_chk;  // test scan entry
    logic finish;    // load result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic init_last;
    logic need_link;
    logic scan_hit;
    logic scan_end;
  } sts_t;

endpackage

[hw/rtl/ght_if.sv]
// ----------------------------------------------------------------------------
// ght_in_if / ght_out_if
// request and response channels of the handle table
// ----------------------------------------------------------------------------
interface ght_in_if;
  logic                   valid;
  logic                   ready;
  logic [2:0]             op;
  logic [31:0]            handle_in;
  logic [31:0]            object_tag;
  logic [3:0]             obj_type;
  logic                   alloc_live;
  logic                   accept_dead;
  logic [10:0]            start_index;
  modport source (output valid, op, handle_in, object_tag, obj_type, alloc_live,
                  accept_dead, start_index, input ready);
  modport sink (input valid, op, handle_in, object_tag, obj_type, alloc_live,
                accept_dead, start_index, output ready);
endinterface

interface ght_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] handle_out;
  logic [31:0] object_out;
  logic [3:0]  type_out;
  logic [10:0] resume_index;
  modport source (output valid, status, handle_out, object_out, type_out, resume_index,
                  input ready);
  modport sink (input valid, status, handle_out, object_out, type_out, resume_index,
                output ready);
endinterface

[hw/rtl/ght_ctrl.sv]
// ----------------------------------------------------------------------------
// ght_ctrl
// sequencer for the handle table operations
// ----------------------------------------------------------------------------
module ght_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            out_busy_i,
  input  logic [2:0]      op_i,
  input  ght_pkg::sts_t   sts_i,
  output ght_pkg::cmd_t   cmd_o
);

  ght_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ght_pkg::SInit;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ght_pkg::SInit: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) begin
          state_d = ght_pkg::SIdle;
        end
      end
      ght_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (op_i == ght_pkg::OpNextUsed) begin
            state_d = ght_pkg::SScanRd;
          end else begin
            state_d = ght_pkg::SRead;
          end
        end
      end
      ght_pkg::SRead: begin
        cmd_o.rd_entry = 1'b1;
        state_d = ght_pkg::SDecide;
      end
      ght_pkg::SDecide: begin
        cmd_o.decide = 1'b1;
        state_d = sts_i.need_link ? ght_pkg::SLinkWr : ght_pkg::SDone;
      end
      ght_pkg::SLinkWr: begin
        cmd_o.wr_link = 1'b1;
        state_d = ght_pkg::SDone;
      end
      ght_pkg::SScanRd: begin
        if (sts_i.scan_end) begin
          state_d = ght_pkg::SDone;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d = ght_pkg::SScanChk;
        end
      end
      ght_pkg::SScanChk: begin
        cmd_o.scan_chk = 1'b1;
        state_d = sts_i.scan_hit ? ght_pkg::SDone : ght_pkg::SScanRd;
      end
      ght_pkg::SDone: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d = ght_pkg::SIdle;
        end
      end
      default: state_d = ght_pkg::SIdle;
    endcase
  end

endmodule

[hw/rtl/ght_dp.sv]
// ----------------------------------------------------------------------------
// ght_dp
// entry memories, free list registers and result register
// ----------------------------------------------------------------------------
module ght_dp #(
  parameter int unsigned ENTRIES    = 1024,
  parameter int unsigned TYPE_WIDTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ght_pkg::cmd_t cmd_i,
  output ght_pkg::sts_t sts_o,
  input  logic [2:0]    op_i,
  input  logic [31:0]   handle_in_i,
  input  logic [31:0]   object_tag_i,
  input  logic [3:0]    obj_type_i,
  input  logic          alloc_live_i,
  input  logic          accept_dead_i,
  input  logic [10:0]   start_index_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    status_o,
  output logic [31:0]   handle_out_o,
  output logic [31:0]   object_out_o,
  output logic [3:0]    type_out_o,
  output logic [10:0]   resume_index_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] Nil = LW'(ENTRIES);
  localparam logic [LW-1:0] LastIdx = LW'(ENTRIES - 1);

  // entry state word: kind, generation, destroyed
  localparam int unsigned SW = TYPE_WIDTH + 3;

  logic [31:0]   obj_mem  [ENTRIES];
  logic [SW-1:0] st_mem   [ENTRIES];
  logic [LW-1:0] prev_mem [ENTRIES];
  logic [LW-1:0] next_mem [ENTRIES];

  logic [2:0]            op_q;
  logic [31:0]           h_q;
  logic [31:0]           obj_q;
  logic [TYPE_WIDTH-1:0] typ_q;
  logic                  mv_q, ign_q;
  logic [LW:0]           scan_q;
  logic [LW-1:0]         init_q;
  logic [LW-1:0]         head_q, tail_q, total_q;
  logic [AW-1:0]         tgt_q;
  logic                  tgt_ok_q;

  logic [SW-1:0]         est_q;
  logic [31:0]           eobj_q;
  logic [LW-1:0]         eprev_q, enext_q;

  logic [2:0]            st_q;
  logic [31:0]           hout_q, oout_q;
  logic [TYPE_WIDTH-1:0] tout_q;
  logic [10:0]           rout_q;
  logic                  link_free_q; // link op is append at tail, else unlink
  logic [LW-1:0]         lp_q, ln_q;
  logic                  valid_q;

  logic [TYPE_WIDTH-1:0] ekind;
  logic [1:0]            egen;
  logic                  edes;
  logic                  hvalid;
  logic                  want_ok;

  logic link_need;
  logic [AW-1:0] idx_w;
  logic          we_st, we_obj;
  logic [SW-1:0] st_w;
  logic [1:0]    gen_bump;

  logic link_free_d;
  logic ln_head_q, ln_tail_q;

  assign ekind = est_q[SW-1:3];
  assign egen  = est_q[2:1];
  assign edes  = est_q[0];
  assign want_ok = (typ_q == '0) || (typ_q == ekind);

  always_comb begin
    hvalid = tgt_ok_q && (h_q[31:30] == egen) && (ekind != '0);
  end

  assign sts_o.init_last = (init_q == LastIdx);
  assign sts_o.scan_end  = (scan_q >= (LW+1)'(ENTRIES));
  assign sts_o.scan_hit  = (ekind != '0);
  assign sts_o.need_link = link_need;

  assign gen_bump = (egen >= 2'd3) ? 2'd1 : egen + 2'd1;

  // decide logic
  always_comb begin
    link_need = 1'b0;
    we_st = 1'b0;
    we_obj = 1'b0;
    st_w = est_q;
    idx_w = tgt_q;
    case (op_q)
      ght_pkg::OpAlloc: begin
        if (typ_q != '0 && total_q != '0 && head_q < Nil) begin
          we_st = 1'b1; we_obj = 1'b1; link_need = 1'b1;
          st_w = {typ_q, egen, ~mv_q};
        end
      end
      ght_pkg::OpAssign: begin
        if (tgt_ok_q && ekind == '0 && typ_q != '0) begin
          we_st = 1'b1; we_obj = 1'b1; link_need = 1'b1;
          st_w = {typ_q, h_q[31:30], 1'b0};
        end
      end
      ght_pkg::OpFree: begin
        if (hvalid && want_ok) begin
          we_st = 1'b1; link_need = 1'b1;
          st_w = {{TYPE_WIDTH{1'b0}}, gen_bump, 1'b0};
        end
      end
      ght_pkg::OpMark: begin
        if (hvalid && !edes) begin
          we_st = 1'b1; st_w = {ekind, egen, 1'b1};
        end
      end
      ght_pkg::OpUnmark: begin
        if (hvalid) begin
          we_st = 1'b1; st_w = {ekind, egen, 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign link_free_d = (op_q == ght_pkg::OpFree) && total_q != '0 && tail_q < Nil;

  logic [AW-1:0] scan_a;
  assign scan_a = scan_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step) begin
      st_mem[init_q[AW-1:0]]   <= {{TYPE_WIDTH{1'b0}}, 2'd1, 1'b0};
      prev_mem[init_q[AW-1:0]] <= (init_q == '0) ? Nil : init_q - LW'(1);
      next_mem[init_q[AW-1:0]] <= init_q + LW'(1);
    end
    if (cmd_i.rd_entry) begin
      est_q   <= st_mem[tgt_q];
      eprev_q <= prev_mem[tgt_q];
      enext_q <= next_mem[tgt_q];
    end
    if (cmd_i.scan_rd) begin
      est_q  <= st_mem[scan_a];
      eobj_q <= obj_mem[scan_a];
    end
    if (cmd_i.decide && op_q == ght_pkg::OpLookup) begin
      eobj_q <= obj_mem[tgt_q];
    end
    if (cmd_i.decide && we_st) begin
      st_mem[idx_w] <= st_w;
    end
    if (cmd_i.decide && we_obj) begin
      obj_mem[idx_w] <= obj_q;
    end
    if (cmd_i.decide && link_need) begin
      prev_mem[idx_w] <= link_free_d ? tail_q : Nil;
      next_mem[idx_w] <= Nil;
    end
    if (cmd_i.wr_link) begin
      if (link_free_q) begin
        if (lp_q < Nil) next_mem[lp_q[AW-1:0]] <= LW'(tgt_q);
      end else begin
        if (lp_q < Nil && !ln_head_q) next_mem[lp_q[AW-1:0]] <= ln_q;
        if (ln_q < Nil && !ln_tail_q) prev_mem[ln_q[AW-1:0]] <= lp_q;
      end
    end
  end

  // free list registers and handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      head_q  <= '0;
      tail_q  <= LastIdx;
      total_q <= Nil;
      valid_q <= 1'b0;
    end else begin
      if (cmd_i.init_step) init_q <= init_q + LW'(1);
      if (cmd_i.finish) valid_q <= 1'b1;
      else if (out_valid_o && out_ready_i) valid_q <= 1'b0;
      if (cmd_i.decide && link_need) begin
        if (op_q == ght_pkg::OpFree) begin
          if (total_q == '0 || tail_q >= Nil) head_q <= LW'(tgt_q);
          tail_q <= LW'(tgt_q);
          if (total_q < Nil) total_q <= total_q + LW'(1);
        end else begin
          if (total_q <= LW'(1)) begin
            head_q <= Nil;
            tail_q <= Nil;
          end else begin
            if (LW'(tgt_q) == head_q) head_q <= enext_q;
            if (LW'(tgt_q) == tail_q) tail_q <= eprev_q;
          end
          if (total_q != '0) total_q <= total_q - LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      h_q    <= handle_in_i;
      obj_q  <= object_tag_i;
      typ_q  <= TYPE_WIDTH'(obj_type_i);
      mv_q   <= alloc_live_i;
      ign_q  <= accept_dead_i;
      scan_q <= (LW+1)'(start_index_i);
      st_q   <= ght_pkg::StInvalid;
      hout_q <= '0;
      oout_q <= '0;
      tout_q <= '0;
      rout_q <= '0;
      if (op_i == ght_pkg::OpAlloc) begin
        tgt_q    <= head_q[AW-1:0];
        tgt_ok_q <= 1'b1;
      end else begin
        tgt_q    <= handle_in_i[6 +: AW];
        tgt_ok_q <= ({8'd0, handle_in_i[29:6]} < 32'(ENTRIES));
      end
    end
    if (cmd_i.decide) begin
      link_free_q <= link_free_d;
      lp_q      <= link_free_d ? tail_q : eprev_q;
      ln_q      <= enext_q;
      ln_head_q <= (LW'(tgt_q) == head_q);
      ln_tail_q <= (LW'(tgt_q) == tail_q);
      case (op_q)
        ght_pkg::OpAlloc: begin
          if (typ_q == '0) st_q <= ght_pkg::StInvalid;
          else if (!link_need) st_q <= ght_pkg::StFull;
          else begin
            st_q   <= ght_pkg::StOk;
            hout_q <= {egen, 24'(tgt_q), 6'd0};
          end
        end
        ght_pkg::OpAssign: begin
          if (!tgt_ok_q) st_q <= ght_pkg::StRange;
          else if (ekind != '0) st_q <= ght_pkg::StNotFree;
          else if (typ_q != '0) st_q <= ght_pkg::StOk;
        end
        ght_pkg::OpFree, ght_pkg::OpMark, ght_pkg::OpUnmark: begin
          if (we_st) st_q <= ght_pkg::StOk;
        end
        ght_pkg::OpLookup: begin
          if (hvalid && want_ok && (!edes || ign_q)) begin
            st_q   <= ght_pkg::StOk;
            tout_q <= ekind;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.scan_chk) begin
      if (ekind != '0) begin
        st_q   <= ght_pkg::StOk;
        hout_q <= {egen, 24'(scan_a), 6'd0};
        oout_q <= eobj_q;
        tout_q <= ekind;
        rout_q <= 11'(scan_q + (LW+1)'(1));
      end else begin
        scan_q <= scan_q + (LW+1)'(1);
      end
    end
  end

  // lookup object comes from the read issued at decide
  logic lk_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lk_q <= 1'b0;
    end else if (cmd_i.decide) begin
      lk_q <= (op_q == ght_pkg::OpLookup) && hvalid && want_ok && (!edes || ign_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      status_o       <= st_q;
      handle_out_o   <= hout_q;
      object_out_o   <= lk_q ? eobj_q : oout_q;
      type_out_o     <= 4'(tout_q);
      resume_index_o <= rout_q;
    end
  end

  assign out_valid_o = valid_q;

endmodule

[hw/rtl/generation_handle_table.sv]
// ----------------------------------------------------------------------------
// generation_handle_table
// fixed-size handle table with generation counts and a linked free list
// ----------------------------------------------------------------------------
// channel  role    word
// req_i    sink    op, handle, object, type, flags, start index
// rsp_o    source  status, handle, object, type, resume index
//
// lookup, mark and unmark pass through read, decide and done; alloc, assign and
// free add a link write when they change the free list and skip it when refused.
// the scan alternates a read and a check of each entry from the start index
// until a hit or the end of the table.
// after reset a clearing pass over all ENTRIES entries runs before the first word.
// a new word is taken only once the previous response has been loaded.
// ----------------------------------------------------------------------------
module generation_handle_table #(
  parameter int unsigned ENTRIES    = 1024,
  parameter int unsigned TYPE_WIDTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  ght_in_if.sink    req_i,
  ght_out_if.source rsp_o
);

  ght_pkg::cmd_t cmd;
  ght_pkg::sts_t sts;

  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .out_busy_i (rsp_o.valid && !rsp_o.ready),
    .op_i       (req_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ght_dp #(
    .ENTRIES    (ENTRIES),
    .TYPE_WIDTH (TYPE_WIDTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .op_i               (req_i.op),
    .handle_in_i        (req_i.handle_in),
    .object_tag_i       (req_i.object_tag),
    .obj_type_i         (req_i.obj_type),
    .alloc_live_i       (req_i.alloc_live),
    .accept_dead_i      (req_i.accept_dead),
    .start_index_i      (req_i.start_index),
    .out_valid_o        (rsp_o.valid),
    .out_ready_i        (rsp_o.ready),
    .status_o           (rsp_o.status),
    .handle_out_o       (rsp_o.handle_out),
    .object_out_o       (rsp_o.object_out),
    .type_out_o         (rsp_o.type_out),
    .resume_index_o     (rsp_o.resume_index)
  );

endmodule
